### rtl/core/lru_keyed_entry_cache_assert.svh
// Assertion macros for the LRU keyed entry cache.
// Used by the top level; no other dependencies.
`ifndef LRU_KEYED_ENTRY_CACHE_ASSERT_SVH
`define LRU_KEYED_ENTRY_CACHE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LKC_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("lkc check failed");
`define LKC_ASSERT_IMPL(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error("lkc check failed");
`else
`define LKC_ASSERT(label, clk, rstn, prop)
`define LKC_ASSERT_IMPL(label, clk, rstn, a, b)
`endif
`endif

### rtl/core/lkc_pkg.sv
// Package for the LRU keyed entry cache: payload structs, status codes, defaults.
// No dependencies.
`default_nettype none
package lkc_pkg;
  localparam int unsigned DefEntries = 16;
  localparam int unsigned DefKeyBits = 32;

  typedef enum logic [2:0] {
    ST_HIT = 3'd0, ST_INSERT = 3'd1, ST_FAIL = 3'd2, ST_EVICT = 3'd3, ST_CLEAR = 3'd4
  } status_e;

  typedef struct packed {
    logic        action;
    logic [31:0] key;
    logic        load_ok;
    logic [13:0] item_width;
    logic [13:0] item_height;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] result_key;
    logic [13:0] width;
    logic [13:0] height;
    logic        last;
  } rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_SCAN, BK_DECIDE, BK_EVICT, BK_INSERT, BK_EMIT
  } back_state_e;
endpackage
`default_nettype wire

### rtl/core/lkc_front.sv
// Front part: accepts request words into a two-entry queue for the back part.
// Depends on lkc_pkg.
`default_nettype none
module lkc_front import lkc_pkg::*; (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  output logic       in_ready_o,
  input  wire  req_t in_data_i,
  output logic       q_valid_o,
  input  wire  logic q_pop_i,
  output req_t       q_data_o
);
  req_t       buf_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = buf_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= in_data_i;
  end
endmodule
`default_nettype wire

### rtl/core/lkc_back.sv
// Back part: scans entries one a cycle, then hits, fails, evicts and inserts; a clear skips the scan.
// Depends on lkc_pkg.
`default_nettype none
module lkc_back import lkc_pkg::*; #(
  parameter int unsigned Entries = DefEntries,
  parameter int unsigned KeyBits = DefKeyBits
) (
  input  wire  logic       clk_i,
  input  wire  logic       rst_ni,
  input  wire  logic       q_valid_i,
  output logic             q_pop_o,
  input  wire  req_t       q_data_i,
  input  wire  logic [4:0] capacity_i,
  output logic             out_valid_o,
  input  wire  logic       out_ready_i,
  output rsp_t             out_data_o,
  output logic             busy_o
);
  localparam int unsigned IW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CW = $clog2(Entries + 1);

  back_state_e st_q, st_d;
  logic [Entries-1:0] vld_q;
  logic [KeyBits-1:0] key_q [Entries];
  logic [13:0] w_q [Entries], h_q [Entries];
  logic [IW-1:0] rank_q [Entries];
  logic [CW-1:0] count_q;
  logic [IW-1:0] idx_q;
  logic hit_q, vic_ok_q, free_ok_q;
  logic [IW-1:0] hit_i_q, vic_i_q, free_i_q;
  req_t req_q;
  rsp_t out_q;
  logic out_v_q;
  logic [CW-1:0] cap_eff;
  logic emit_ok;
  logic evict_pass_q;

  assign cap_eff = (capacity_i == 5'd0) ? CW'(1) :
                   ({27'd0, capacity_i} > 32'(Entries)) ? CW'(Entries) : CW'(capacity_i);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
  assign busy_o      = (st_q != BK_IDLE);
  assign emit_ok     = !out_v_q || out_ready_i;

  always_comb begin
    st_d = st_q;
    case (st_q)
      BK_IDLE:   if (q_valid_i) st_d = q_data_i.action ? BK_EMIT : BK_SCAN;
      BK_SCAN:   if (idx_q == IW'(Entries - 1)) st_d = BK_DECIDE;
      BK_DECIDE: begin
        if (hit_q || !req_q.load_ok) st_d = BK_EMIT;
        else if (count_q != '0 && count_q >= cap_eff) st_d = BK_EVICT;
        else st_d = BK_INSERT;
      end
      BK_EVICT:  if (emit_ok) st_d = BK_SCAN;
      BK_INSERT, BK_EMIT: if (emit_ok) st_d = BK_IDLE;
      default:   st_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o = (st_q == BK_IDLE) && q_valid_i;
  end

  // Scan pass: find the lowest matching slot, the oldest slot (rank count-1) and
  // the lowest free slot. After each eviction the scan reruns to find the next
  // victim and the lowest free slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE; vld_q <= '0; count_q <= '0; out_v_q <= 1'b0;
      idx_q <= '0; evict_pass_q <= 1'b0;
      for (int i = 0; i < Entries; i++) rank_q[i] <= '0;
    end else begin
      st_q <= st_d;
      out_v_q <= (out_v_q && !out_ready_i) ||
                 (emit_ok && (st_q == BK_EVICT || st_q == BK_INSERT || st_q == BK_EMIT));
      case (st_q)
        BK_IDLE: begin
          idx_q <= '0; evict_pass_q <= 1'b0;
          hit_q <= 1'b0; vic_ok_q <= 1'b0; free_ok_q <= 1'b0;
          if (q_valid_i) req_q <= q_data_i;
          if (q_valid_i && q_data_i.action) begin
            vld_q <= '0; count_q <= '0;
            for (int i = 0; i < Entries; i++) rank_q[i] <= '0;
          end
          hit_i_q <= '0; vic_i_q <= '0; free_i_q <= '0;
        end
        BK_SCAN: begin
          idx_q <= idx_q + IW'(1);
          if (vld_q[idx_q] && !evict_pass_q && key_q[idx_q] == KeyBits'(req_q.key) && !hit_q) begin
            hit_q <= 1'b1; hit_i_q <= idx_q;
          end
          if (vld_q[idx_q] && CW'(rank_q[idx_q]) == count_q - CW'(1) && !vic_ok_q) begin
            vic_ok_q <= 1'b1; vic_i_q <= idx_q;
          end
          if (!vld_q[idx_q] && !free_ok_q) begin
            free_ok_q <= 1'b1; free_i_q <= idx_q;
          end
        end
        BK_DECIDE: begin
          idx_q <= '0;
          if (hit_q) begin
            for (int j = 0; j < Entries; j++)
              if (vld_q[j] && rank_q[j] < rank_q[hit_i_q]) rank_q[j] <= rank_q[j] + IW'(1);
            rank_q[hit_i_q] <= '0;
            evict_pass_q <= 1'b0;
          end else if (req_q.load_ok && count_q != '0 && count_q >= cap_eff) begin
            vld_q[vic_i_q] <= 1'b0; rank_q[vic_i_q] <= '0;
            count_q <= count_q - CW'(1);
            free_ok_q <= 1'b0; vic_ok_q <= 1'b0;
          end else begin
            evict_pass_q <= 1'b0;
          end
        end
        BK_EVICT: if (emit_ok) begin
          out_q <= '{status: ST_EVICT, slot: 4'(vic_i_q), result_key: 32'(key_q[vic_i_q]),
                     width: '0, height: '0, last: 1'b0};
          evict_pass_q <= 1'b1; idx_q <= '0;
        end
        BK_INSERT: if (emit_ok) begin
          out_q <= '{status: ST_INSERT, slot: 4'(free_i_q), result_key: req_q.key,
                     width: req_q.item_width, height: req_q.item_height, last: 1'b1};
          for (int j = 0; j < Entries; j++)
            if (vld_q[j]) rank_q[j] <= rank_q[j] + IW'(1);
          vld_q[free_i_q] <= 1'b1; rank_q[free_i_q] <= '0;
          count_q <= count_q + CW'(1);
        end
        BK_EMIT: if (emit_ok) begin
          if (req_q.action)
            out_q <= '{status: ST_CLEAR, slot: '0, result_key: req_q.key,
                       width: '0, height: '0, last: 1'b1};
          else if (hit_q)
            out_q <= '{status: ST_HIT, slot: 4'(hit_i_q), result_key: req_q.key,
                       width: w_q[hit_i_q], height: h_q[hit_i_q], last: 1'b1};
          else
            out_q <= '{status: ST_FAIL, slot: '0, result_key: req_q.key,
                       width: '0, height: '0, last: 1'b1};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BK_INSERT && emit_ok) begin
      key_q[free_i_q] <= KeyBits'(req_q.key);
      w_q[free_i_q]   <= req_q.item_width;
      h_q[free_i_q]   <= req_q.item_height;
    end
  end
endmodule
`default_nettype wire

### rtl/core/lru_keyed_entry_cache.sv
// LRU keyed entry cache, fully associative, least-recently-used replacement.
// Request words enter on in_*, results leave on out_*, capacity is set over APB.
// Each request is queued by the front part (two words deep); the back part
// scans every entry once per request, one entry a cycle, then decides on a hit,
// failed load, eviction or plain insert, and each eviction adds one more scan
// and a decision. A clear skips the scan. Results sit in an output register:
// when the receiver stalls the back part holds, the queue fills, then
// in_ready_o drops.
// A miss with a good load gives one evicted word per eviction, then the
// inserted word with last set. Reset empties the cache and sets capacity 16.
// Depends on lkc_pkg, lkc_front, lkc_back and the assertion header.
`default_nettype none
`include "lru_keyed_entry_cache_assert.svh"
module lru_keyed_entry_cache import lkc_pkg::*; #(
  parameter int unsigned Entries = DefEntries,
  parameter int unsigned KeyBits = DefKeyBits
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        in_valid_i,
  output logic              in_ready_o,
  input  wire  req_t        in_data_i,
  output logic              out_valid_o,
  input  wire  logic        out_ready_i,
  output rsp_t              out_data_o,
  input  wire  logic        psel,
  input  wire  logic        penable,
  input  wire  logic        pwrite,
  input  wire  logic [1:0]  paddr,
  input  wire  logic [31:0] pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  logic [4:0] cap_q;
  logic q_valid, q_pop, busy;
  req_t q_data;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {27'd0, cap_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= 5'd16;
    else if (psel && penable && pwrite && paddr == 2'd0) cap_q <= pwdata[4:0];
  end

  lkc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  lkc_back #(.Entries(Entries), .KeyBits(KeyBits)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .capacity_i(cap_q), .out_valid_o, .out_ready_i, .out_data_o, .busy_o(busy)
  );

  `LKC_ASSERT_IMPL(a_pop_idle, clk_i, rst_ni, q_pop, !busy)
  `LKC_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> $stable(out_data_o))
endmodule
`default_nettype wire

### tb/tb_lru_keyed_entry_cache.sv
// Testbench for the LRU keyed entry cache: random and directed request words,
// a per-request predictor of the LRU state, and a scoreboard of result words.
// Depends on lkc_pkg and the lru_keyed_entry_cache top level.
`timescale 1ns / 1ps
module tb_lru_keyed_entry_cache;
  import lkc_pkg::*;

  localparam int unsigned Slots = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  req_t        in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  rsp_t        out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lru_keyed_entry_cache DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // Predicted cache contents.
  logic        line_valid [Slots];
  logic [31:0] line_key [Slots];
  logic [13:0] line_w [Slots];
  logic [13:0] line_h [Slots];
  int unsigned line_age [Slots];
  int unsigned line_count;
  int unsigned cache_cap;

  req_t pending_words[$];
  rsp_t expected_results[$];
  int   error_count = 0;
  int   results_seen = 0;
  int   evictions_seen = 0;
  int   hits_seen = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   driving = 1'b0;

  function automatic rsp_t make_rsp(status_e st, int unsigned sl, logic [31:0] k,
                                    logic [13:0] w, logic [13:0] h, logic lst);
    rsp_t r;
    r.status = st;
    r.slot = sl[3:0];
    r.result_key = k;
    r.width = w;
    r.height = h;
    r.last = lst;
    return r;
  endfunction

  // Updates the predicted cache for one request and queues its results.
  task automatic predict_lookup(req_t q);
    int hit_slot;
    int victim;
    int free_slot;
    int unsigned cap;
    int unsigned r;
    hit_slot = -1;
    if (q.action) begin
      for (int i = 0; i < Slots; i++) begin
        line_valid[i] = 1'b0;
        line_age[i] = 0;
      end
      line_count = 0;
      expected_results.push_back(make_rsp(ST_CLEAR, 0, q.key, '0, '0, 1'b1));
      return;
    end
    for (int i = 0; i < Slots; i++)
      if (hit_slot < 0 && line_valid[i] && line_key[i] == q.key) hit_slot = i;
    if (hit_slot >= 0) begin
      r = line_age[hit_slot];
      for (int j = 0; j < Slots; j++)
        if (line_valid[j] && line_age[j] < r) line_age[j]++;
      line_age[hit_slot] = 0;
      expected_results.push_back(make_rsp(ST_HIT, hit_slot, q.key, line_w[hit_slot],
                                          line_h[hit_slot], 1'b1));
      return;
    end
    if (!q.load_ok) begin
      expected_results.push_back(make_rsp(ST_FAIL, 0, q.key, '0, '0, 1'b1));
      return;
    end
    cap = (cache_cap > Slots) ? Slots : cache_cap;
    while (line_count > 0 && line_count >= cap) begin
      victim = -1;
      for (int i = 0; i < Slots; i++)
        if (victim < 0 && line_valid[i] && line_age[i] == line_count - 1) victim = i;
      if (victim < 0) break;
      line_valid[victim] = 1'b0;
      line_age[victim] = 0;
      line_count--;
      expected_results.push_back(make_rsp(ST_EVICT, victim, line_key[victim], '0, '0,
                                          1'b0));
    end
    free_slot = -1;
    for (int i = 0; i < Slots; i++)
      if (free_slot < 0 && !line_valid[i]) free_slot = i;
    if (free_slot >= 0) begin
      for (int j = 0; j < Slots; j++)
        if (line_valid[j]) line_age[j]++;
      line_valid[free_slot] = 1'b1;
      line_key[free_slot] = q.key;
      line_w[free_slot] = q.item_width;
      line_h[free_slot] = q.item_height;
      line_age[free_slot] = 0;
      line_count++;
      expected_results.push_back(make_rsp(ST_INSERT, free_slot, q.key, q.item_width,
                                          q.item_height, 1'b1));
    end
  endtask

  // Driver: prediction happens at acceptance, so it follows the block's order.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) predict_lookup(in_data_i);
    if (!in_valid_i || in_ready_o) begin
      if (driving && pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_words.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: compares each result word with the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t e;
    if (out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result word: %p", out_data_o);
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (e.status == ST_EVICT) evictions_seen++;
        if (e.status == ST_HIT) hits_seen++;
        if (out_data_o.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_data_o.status);
          error_count++;
        end
        if (out_data_o.slot !== e.slot) begin
          $error("slot: expected %0d, got %0d", e.slot, out_data_o.slot);
          error_count++;
        end
        if (out_data_o.result_key !== e.result_key) begin
          $error("result_key: expected %h, got %h", e.result_key, out_data_o.result_key);
          error_count++;
        end
        if (out_data_o.width !== e.width) begin
          $error("width: expected %0d, got %0d", e.width, out_data_o.width);
          error_count++;
        end
        if (out_data_o.height !== e.height) begin
          $error("height: expected %0d, got %0d", e.height, out_data_o.height);
          error_count++;
        end
        if (out_data_o.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_data_o.last);
          error_count++;
        end
      end
    end
  end

  task automatic write_capacity(int unsigned value);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cache_cap = value & 31;
  endtask

  function automatic req_t make_req(logic act, logic [31:0] k, logic ok,
                                    logic [13:0] w, logic [13:0] h);
    req_t q;
    q.action = act;
    q.key = k;
    q.load_ok = ok;
    q.item_width = w;
    q.item_height = h;
    return q;
  endfunction

  // Keys come from a small pool so hits and evictions are common.
  function automatic req_t random_req(int unsigned pool);
    logic [31:0] k;
    k = ($urandom_range(9) == 0) ? $urandom() : 32'hA500_0000 + $urandom_range(pool - 1);
    return make_req($urandom_range(29) == 0, k, $urandom_range(9) != 0,
                    14'($urandom_range(16383)), 14'($urandom_range(16383)));
  endfunction

  task automatic run_phase();
    driving = 1'b1;
    wait (pending_words.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    driving = 1'b0;
    // The block is idle once the last expected result is seen; wait before the next phase.
    repeat (200) @(posedge clk_i);
  endtask

  initial begin
    int unsigned caps [4] = '{16, 1, 5, 31};
    int unsigned pcts [3][2] = '{'{29, 59}, '{59, 29}, '{0, 0}};
    for (int i = 0; i < Slots; i++) begin
      line_valid[i] = 1'b0;
      line_age[i] = 0;
      line_key[i] = '0;
      line_w[i] = '0;
      line_h[i] = '0;
    end
    line_count = 0;
    cache_cap = 16;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: extremes, hit, failed load, fill past capacity, clear.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pending_words.push_back(make_req(1'b0, 32'h0000_0000, 1'b1, 14'h3FFF, 14'h0000));
    pending_words.push_back(make_req(1'b0, 32'hFFFF_FFFF, 1'b1, 14'h0000, 14'h3FFF));
    pending_words.push_back(make_req(1'b0, 32'h0000_0000, 1'b0, 14'h1234, 14'h0123));
    pending_words.push_back(make_req(1'b0, 32'h5555_AAAA, 1'b0, 14'h2AAA, 14'h1555));
    for (int i = 0; i < 17; i++)
      pending_words.push_back(make_req(1'b0, 32'hC000_0000 + i, 1'b1, 14'(i),
                                       14'(16383 - i)));
    pending_words.push_back(make_req(1'b0, 32'hFFFF_FFFF, 1'b0, 14'h0, 14'h0));
    pending_words.push_back(make_req(1'b1, 32'hAAAA_5555, 1'b1, 14'h3FFF, 14'h3FFF));
    pending_words.push_back(make_req(1'b0, 32'hC000_0003, 1'b0, 14'h0, 14'h0));
    run_phase();

    // Capacity zero behaves like one: each insert evicts the previous entry.
    write_capacity(0);
    for (int i = 0; i < 3; i++)
      pending_words.push_back(make_req(1'b0, 32'hD000_0000 + i, 1'b1, 14'd7, 14'd9));
    run_phase();

    for (int p = 0; p < 4; p++) begin
      write_capacity(caps[p]);
      for (int s = 0; s < 3; s++) begin
        send_idle_pct = pcts[s][0];
        recv_idle_pct = pcts[s][1];
        for (int n = 0; n < 11; n++)
          pending_words.push_back(random_req(caps[p] > 16 ? 24 : caps[p] + 3));
        run_phase();
      end
    end

    $display("covered %0d result words, %0d hits, %0d evictions, capacity 0 to 31",
             results_seen, hits_seen, evictions_seen);
    if (error_count == 0) begin
      $display("tb_lru_keyed_entry_cache: done, clean");
    end else begin
      $display("tb_lru_keyed_entry_cache: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_lru_keyed_entry_cache: done, errors");
    $finish;
  end
endmodule
